// File: rtl/ddm_pkg.sv
// ----------------------------------------------------------------------------
// ddm_pkg: shared types and constants
// Frame command, colour bundle, register indexes, digit font, divide-by-ten.
// ----------------------------------------------------------------------------
package ddm_pkg;

	localparam int DIGIT_W   = 4;
	localparam int LEVEL_W   = 8;
	localparam int DEB_W     = 16;
	localparam int TIME_W    = 32;
	localparam int PIXEL_W   = 24;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 16;
	localparam int SIDE      = 5;

	localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

	localparam logic [CFG_IDX_W-1:0] REG_RED      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GREEN    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BLUE     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 3'd3;

	typedef struct packed {
		logic [DIGIT_W-1:0] digit;
	} cmd_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] g;
		logic [LEVEL_W-1:0] r;
		logic [LEVEL_W-1:0] b;
	} colour_t;

	// x/10 for x < 256: multiply by 205, drop 11 bits
	function automatic logic [LEVEL_W-1:0] div10(input logic [LEVEL_W-1:0] x);
		logic [18:0] p;
		begin
			p = 19'(x) * 19'd205;
			div10 = p[18:11];
		end
	endfunction

	// glyph rows top to bottom, row 0 in bits 24..20; bit 4 of a row is column 0
	function automatic logic [SIDE*SIDE-1:0] glyph(input logic [DIGIT_W-1:0] d);
		begin
			unique case (d)
				4'd1: glyph = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h0E};
				4'd2: glyph = {5'h0E, 5'h11, 5'h02, 5'h04, 5'h1F};
				4'd3: glyph = {5'h1E, 5'h01, 5'h0E, 5'h01, 5'h1E};
				4'd4: glyph = {5'h02, 5'h06, 5'h0A, 5'h1F, 5'h02};
				4'd5: glyph = {5'h1F, 5'h10, 5'h1E, 5'h01, 5'h1E};
				4'd6: glyph = {5'h0E, 5'h10, 5'h1E, 5'h11, 5'h0E};
				4'd7: glyph = {5'h1F, 5'h02, 5'h04, 5'h08, 5'h08};
				4'd8: glyph = {5'h0E, 5'h11, 5'h0E, 5'h11, 5'h0E};
				4'd9: glyph = {5'h0E, 5'h11, 5'h0F, 5'h01, 5'h0E};
				default: glyph = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h0E};
			endcase
		end
	endfunction

endpackage

// File: rtl/ddm_front.sv
// ----------------------------------------------------------------------------
// ddm_front: button event classifier
// Tracks pressed flags and debounce times, steps the digit, queues frames.
// ----------------------------------------------------------------------------
module ddm_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic                          button,
	input  logic                          level,
	input  logic [ddm_pkg::TIME_W-1:0]    now_ms,
	input  logic [ddm_pkg::DEB_W-1:0]     debounce_ms,
	output logic                          cmd_push,
	output ddm_pkg::cmd_t                 cmd
);
	import ddm_pkg::*;

	logic [DIGIT_W-1:0] digit_q;
	logic               pressed_up_q, pressed_dn_q;
	logic [TIME_W-1:0]  time_up_q, time_dn_q;

	logic [TIME_W-1:0]  last_t, elapsed;
	logic               pressed, settled, fire;
	logic [DIGIT_W-1:0] digit_nxt;

	assign last_t  = button ? time_dn_q : time_up_q;
	assign pressed = button ? pressed_dn_q : pressed_up_q;
	assign elapsed = now_ms - last_t;   // wraps mod 2^32
	assign settled = elapsed >= TIME_W'(debounce_ms);
	assign fire    = accept && !level && !pressed && settled;

	always_comb begin
		if (!button) begin
			digit_nxt = (digit_q >= DIGIT_MAX) ? '0 : digit_q + 4'd1;
		end else begin
			digit_nxt = (digit_q == '0) ? DIGIT_MAX : digit_q - 4'd1;
		end
	end

	assign cmd_push  = fire;
	assign cmd.digit = digit_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q      <= '0;
			pressed_up_q <= 1'b0;
			pressed_dn_q <= 1'b0;
			time_up_q    <= '0;
			time_dn_q    <= '0;
		end else if (fire) begin
			digit_q <= digit_nxt;
			if (!button) begin
				pressed_up_q <= 1'b1;
				time_up_q    <= now_ms;
			end else begin
				pressed_dn_q <= 1'b1;
				time_dn_q    <= now_ms;
			end
		end else if (accept && level) begin
			if (!button) begin
				pressed_up_q <= 1'b0;
			end else begin
				pressed_dn_q <= 1'b0;
			end
		end
	end

endmodule

// File: rtl/ddm_cmd_fifo.sv
// ----------------------------------------------------------------------------
// ddm_cmd_fifo: frame command queue
// Small register queue between classifier and pixel sequencer.
// ----------------------------------------------------------------------------
module ddm_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ddm_pkg::cmd_t wdata,
	output logic          full,
	input  logic          pop,
	output ddm_pkg::cmd_t rdata,
	output logic          empty
);
	import ddm_pkg::*;

	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full  = count_q == (PTR_W+1)'(DEPTH);
	assign empty = count_q == '0;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop && !empty) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			unique case ({push && !full, pop && !empty})
				2'b10:   count_q <= count_q + (PTR_W+1)'(1);
				2'b01:   count_q <= count_q - (PTR_W+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: rtl/ddm_back.sv
// ----------------------------------------------------------------------------
// ddm_back: pixel sequencer
// Walks the 5x5 frame one pixel a cycle, stalls on a full output register.
// ----------------------------------------------------------------------------
module ddm_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cmd_empty,
	input  ddm_pkg::cmd_t                cmd,
	output logic                         cmd_pop,
	input  ddm_pkg::colour_t             colour,
	output logic                         empty,
	input  logic                         pop,
	output logic [ddm_pkg::PIXEL_W-1:0]  grb_word,
	output logic                         last_pixel,
	output logic [ddm_pkg::DIGIT_W-1:0]  shown_digit
);
	import ddm_pkg::*;

	logic               busy_q, out_valid_q;
	logic [DIGIT_W-1:0] digit_q;
	logic [2:0]         row_q, col_q;
	logic [PIXEL_W-1:0] pixel_q;
	logic               last_q;
	logic [DIGIT_W-1:0] shown_q;

	logic               adv, at_end, lit, load;
	logic [SIDE*SIDE-1:0] bits;
	logic [4:0]         bit_idx;

	assign adv    = !out_valid_q || pop;
	assign at_end = (row_q == 3'd4) && (col_q == 3'd4);
	assign load   = !cmd_empty && (!busy_q || (adv && at_end));
	assign cmd_pop = load;

	// frame row r shows glyph row 4-r: glyph bit 4 + 5*r - col
	assign bits    = glyph(digit_q);
	assign bit_idx = 5'(row_q) * 5'd5 + 5'd4 - 5'(col_q);
	assign lit     = bits[bit_idx];

	always_ff @(posedge clk) begin
		if (adv && busy_q) begin
			pixel_q <= lit ? {colour.g, colour.r, colour.b} : '0;
			last_q  <= at_end;
			shown_q <= digit_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			digit_q     <= '0;
			row_q       <= '0;
			col_q       <= '0;
		end else begin
			if (adv) begin
				out_valid_q <= busy_q;
			end
			if (load) begin
				busy_q  <= 1'b1;
				digit_q <= cmd.digit;
				row_q   <= '0;
				col_q   <= '0;
			end else if (busy_q && adv) begin
				if (at_end) begin
					busy_q <= 1'b0;
				end else if (col_q == 3'd4) begin
					col_q <= '0;
					row_q <= row_q + 3'd1;
				end else begin
					col_q <= col_q + 3'd1;
				end
			end
		end
	end

	assign empty       = !out_valid_q;
	assign grb_word    = pixel_q;
	assign last_pixel  = last_q;
	assign shown_digit = shown_q;

endmodule

// File: rtl/debounced_digit_matrix_driver.sv
// ----------------------------------------------------------------------------
// debounced_digit_matrix_driver: debounced up/down digit on a 5x5 pixel matrix
// Button events in, 25 GRB pixel words per accepted press out.
// ----------------------------------------------------------------------------
// Usage:
//  - Input queue: drive button/level/now_ms with push; a transaction happens
//    when push is high and full is low. Events are classified right away:
//    a debounced press steps the digit and queues one frame command.
//  - Output queue: while empty is low the oldest pixel sits on grb_word,
//    last_pixel, shown_digit; pop takes it. Each frame is 25 transactions,
//    pixel row*5+col, last_pixel marks the 25th.
//  - Path: command queue, then pixel sequencer, then output register.
//  - Throughput: one pixel per cycle while pop is held, set by the single
//    pixel sequencer. Back-to-back frames run with no gap.
//  - Input events are taken every cycle while the 4-entry command queue has
//    room; full rises only when 4 frames are pending behind the sequencer.
//  - When the receiver stalls, the output register holds its word and the
//    sequencer waits; commands back up in the queue, then full asserts.
//  - Configuration: cfg_valid/cfg_ready write channel, cfg_ready always high.
//    Index 0 red, 1 green, 2 blue, 3 debounce ms; others are dropped.
//    Write only while idle.
//  - Reset (arst_n low): digit 0, both buttons released, accept times 0,
//    colour 0/0/20, debounce 100 ms, queues empty.
// ----------------------------------------------------------------------------
module debounced_digit_matrix_driver (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic                           button,
	input  logic                           level,
	input  logic [ddm_pkg::TIME_W-1:0]     now_ms,
	output logic                           empty,
	input  logic                           pop,
	output logic [ddm_pkg::PIXEL_W-1:0]    grb_word,
	output logic                           last_pixel,
	output logic [ddm_pkg::DIGIT_W-1:0]    shown_digit,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ddm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ddm_pkg::CFG_DAT_W-1:0]  cfg_data
);
	import ddm_pkg::*;

	// configuration registers
	logic [LEVEL_W-1:0] red_q, green_q, blue_q;
	logic [DEB_W-1:0]   debounce_q;

	// front/back hookup
	logic    accept;
	logic    cmd_push, cmd_pop, cmd_empty;
	cmd_t    cmd_in, cmd_out;
	colour_t colour;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_q      <= 8'd0;
			green_q    <= 8'd0;
			blue_q     <= 8'd20;
			debounce_q <= 16'd100;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_RED:      red_q      <= cfg_data[LEVEL_W-1:0];
				REG_GREEN:    green_q    <= cfg_data[LEVEL_W-1:0];
				REG_BLUE:     blue_q     <= cfg_data[LEVEL_W-1:0];
				REG_DEBOUNCE: debounce_q <= cfg_data;
				default: ;    // unmapped index, write dropped
			endcase
		end
	end

	// tenfold dimming of the lit colour; the user keeps it stable while frames are in flight, unenforced
	assign colour.g = div10(green_q);
	assign colour.r = div10(red_q);
	assign colour.b = div10(blue_q);

	assign accept = push && !full;

	ddm_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.button      (button),
		.level       (level),
		.now_ms      (now_ms),
		.debounce_ms (debounce_q),
		.cmd_push    (cmd_push),
		.cmd         (cmd_in)
	);

	ddm_cmd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_in),
		.full   (full),
		.pop    (cmd_pop),
		.rdata  (cmd_out),
		.empty  (cmd_empty)
	);

	ddm_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_empty   (cmd_empty),
		.cmd         (cmd_out),
		.cmd_pop     (cmd_pop),
		.colour      (colour),
		.empty       (empty),
		.pop         (pop),
		.grb_word    (grb_word),
		.last_pixel  (last_pixel),
		.shown_digit (shown_digit)
	);

`ifndef SYNTH
	// a frame command is never offered to a full queue
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !cmd_push)
		else $error("frame command pushed into full queue");

	// every shown word carries a decimal digit
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (shown_digit <= DIGIT_MAX))
		else $error("shown digit out of range");

	// a frame command only comes from an accepted low-level event
	a_cmd_from_press: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |-> (accept && !level))
		else $error("frame queued without a press");
`endif

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: debounced digit matrix driver
// Drives button edge events into the input queue and takes 25 pixel words
// per accepted press from the output queue. A scoreboard class predicts the
// debounce, the up/down digit and the GRB frame, and checks every pixel in
// order. Phases cover the reset colours, register extremes, zero debounce
// with a long receiver stall that fills the block, dark frames and random settings.
// ----------------------------------------------------------------------------
module testbench;
	import ddm_pkg::*;

	// button and line-level codes (levels are active low)
	localparam logic BTN_UP         = 1'b0;
	localparam logic BTN_DOWN       = 1'b1;
	localparam logic LEVEL_PRESSED  = 1'b0;
	localparam logic LEVEL_RELEASED = 1'b1;

	// register indexes past the list, written to check that they are dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	localparam int FRAME_LEN      = SIDE * SIDE;
	localparam int IDLE_PCT       = 10;    // idle cycles per hundred, each side
	localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
	localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transaction at all
	localparam int DRAIN_CYCLES   = 8;     // settle time before a register write

	// digit font, rows top to bottom; bit 4 of a row is column 0
	localparam logic [4:0] FONT [10][5] = '{
		'{5'h0E, 5'h11, 5'h11, 5'h11, 5'h0E},
		'{5'h04, 5'h0C, 5'h04, 5'h04, 5'h0E},
		'{5'h0E, 5'h11, 5'h02, 5'h04, 5'h1F},
		'{5'h1E, 5'h01, 5'h0E, 5'h01, 5'h1E},
		'{5'h02, 5'h06, 5'h0A, 5'h1F, 5'h02},
		'{5'h1F, 5'h10, 5'h1E, 5'h01, 5'h1E},
		'{5'h0E, 5'h10, 5'h1E, 5'h11, 5'h0E},
		'{5'h1F, 5'h02, 5'h04, 5'h08, 5'h08},
		'{5'h0E, 5'h11, 5'h0E, 5'h11, 5'h0E},
		'{5'h0E, 5'h11, 5'h0F, 5'h01, 5'h0E}
	};

	typedef struct packed {
		logic [PIXEL_W-1:0] grb;
		logic               last;
		logic [DIGIT_W-1:0] digit;
	} pixel_t;

	// ------------------------------------------------------------------------
	// Scoreboard: own copy of registers and button state, queue of the
	// pixel words still owed by the block.
	// ------------------------------------------------------------------------
	class frame_model;
		logic [LEVEL_W-1:0] red, green, blue;
		logic [DEB_W-1:0]   debounce;
		logic [DIGIT_W-1:0] digit;
		logic               pressed [2];
		logic [TIME_W-1:0]  accept_t [2];
		pixel_t             expected_pixels [$];
		int                 mismatches;

		function new();
			red = '0;
			green = '0;
			blue = 8'd20;
			debounce = 16'd100;
			digit = '0;
			pressed[0] = 1'b0;
			pressed[1] = 1'b0;
			accept_t[0] = '0;
			accept_t[1] = '0;
			mismatches = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
			case (idx)
				REG_RED:      red = data[LEVEL_W-1:0];
				REG_GREEN:    green = data[LEVEL_W-1:0];
				REG_BLUE:     blue = data[LEVEL_W-1:0];
				REG_DEBOUNCE: debounce = data;
				default: ;
			endcase
		endfunction

		// one frame for the current digit, rows flipped vertically
		function void predict_frame();
			logic [PIXEL_W-1:0] colour;
			pixel_t px;
			int row, col;
			colour = {green / 8'd10, red / 8'd10, blue / 8'd10};
			for (int k = 0; k < FRAME_LEN; k++) begin
				row = k / SIDE;
				col = k % SIDE;
				px.grb = FONT[digit][4 - row][4 - col] ? colour : '0;
				px.last = (k == FRAME_LEN - 1);
				px.digit = digit;
				expected_pixels.push_back(px);
			end
		endfunction

		// accepted input transaction
		function void note_event(logic btn, logic lvl, logic [TIME_W-1:0] stamp);
			logic [TIME_W-1:0] since;
			since = stamp - accept_t[btn];
			if (lvl == LEVEL_PRESSED && !pressed[btn]) begin
				if (since >= TIME_W'(debounce)) begin
					pressed[btn] = 1'b1;
					accept_t[btn] = stamp;
					if (btn == BTN_UP)
						digit = (digit == DIGIT_MAX) ? '0 : digit + 4'd1;
					else
						digit = (digit == '0) ? DIGIT_MAX : digit - 4'd1;
					predict_frame();
				end
			end else if (lvl == LEVEL_RELEASED) begin
				pressed[btn] = 1'b0;
			end
		endfunction

		// accepted output transaction
		function void check_pixel(logic [PIXEL_W-1:0] grb, logic last, logic [DIGIT_W-1:0] dig);
			pixel_t want;
			if (expected_pixels.size() == 0) begin
				$display("%0t: unexpected pixel grb %h last %b digit %0d", $time, grb, last, dig);
				mismatches++;
			end else begin
				want = expected_pixels.pop_front();
				if (grb !== want.grb) begin
					$display("%0t: grb_word expected %h actual %h", $time, want.grb, grb);
					mismatches++;
				end
				if (last !== want.last) begin
					$display("%0t: last_pixel expected %b actual %b", $time, want.last, last);
					mismatches++;
				end
				if (dig !== want.digit) begin
					$display("%0t: shown_digit expected %0d actual %0d", $time, want.digit, dig);
					mismatches++;
				end
			end
		endfunction

		function int pending();
			return expected_pixels.size();
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Clock, reset and block ports; every input known from time zero.
	// ------------------------------------------------------------------------
	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 push = 1'b0;
	logic                 full;
	logic                 button = 1'b0;
	logic                 level = 1'b1;
	logic [TIME_W-1:0]    now_ms = '0;
	logic                 empty;
	logic                 pop = 1'b0;
	logic [PIXEL_W-1:0]   grb_word;
	logic                 last_pixel;
	logic [DIGIT_W-1:0]   shown_digit;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data = '0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	debounced_digit_matrix_driver dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.button      (button),
		.level       (level),
		.now_ms      (now_ms),
		.empty       (empty),
		.pop         (pop),
		.grb_word    (grb_word),
		.last_pixel  (last_pixel),
		.shown_digit (shown_digit),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	frame_model sb;

	logic              steady = 1'b0;     // no random idling on either side
	logic              stall_req = 1'b0;  // ask the receiver for a long hold-off
	int                hold_left = 0;     // receiver hold-off, counted in cycles
	int                idle_cycles = 0;   // watchdog count
	logic [TIME_W-1:0] clock_ms = '0;     // running event time for sequences
	logic [DEB_W-1:0]  cur_debounce = 16'd100;

	// ------------------------------------------------------------------------
	// Receiver. Outputs sampled at the rising edge; pop changes at the falling
	// edge. A stall request starts a hold-off that this process counts down.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (sb != null && pop && !empty)
			sb.check_pixel(grb_word, last_pixel, shown_digit);
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end else if (stall_req) begin
			hold_left <= HOLD_CYCLES;
			stall_req = 1'b0;
		end
	end

	always @(negedge clk) begin
		pop <= (hold_left == 0) && (steady || $urandom_range(0, 99) >= IDLE_PCT);
	end

	// ------------------------------------------------------------------------
	// Watchdog: any transaction on any channel resets the count.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog, no transaction for %0d cycles", $time, idle_cycles);
			$display("TEST FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// ------------------------------------------------------------------------
	// Sender tasks. All are entered and left at a falling edge.
	// ------------------------------------------------------------------------

	// one input transaction; push stays high for a following event
	task automatic send_event(logic btn, logic lvl, logic [TIME_W-1:0] stamp);
		int gap;
		if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			gap = $urandom_range(1, 4);
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push <= 1'b1;
		button <= btn;
		level <= lvl;
		now_ms <= stamp;
		do @(posedge clk); while (full);
		sb.note_event(btn, lvl, stamp);
		@(negedge clk);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, data);
		@(negedge clk);
	endtask

	// all four registers plus a write to an index past the list
	task automatic program_regs(logic [CFG_DAT_W-1:0] r, logic [CFG_DAT_W-1:0] g,
			logic [CFG_DAT_W-1:0] b, logic [CFG_DAT_W-1:0] deb,
			logic [CFG_IDX_W-1:0] spare);
		cfg_write(REG_RED, r);
		cfg_write(REG_GREEN, g);
		cfg_write(REG_BLUE, b);
		cfg_write(REG_DEBOUNCE, deb);
		cfg_write(spare, CFG_DAT_W'($urandom()));
		cfg_valid <= 1'b0;
		cur_debounce = deb;
	endtask

	// wait until every owed pixel has left, then let the block go quiet
	task automatic settle();
		push <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// mostly release-then-press sequences, some bounces and random noise
	task automatic random_events(int count);
		int sent;
		logic btn;
		logic [TIME_W-1:0] gap;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(0, 99) < 80) begin
				btn = 1'($urandom_range(0, 1));
				send_event(btn, LEVEL_RELEASED, clock_ms);
				// a quarter of the gaps may fall inside the debounce window
				if ($urandom_range(0, 3) == 0)
					gap = $urandom_range(0, cur_debounce);
				else
					gap = TIME_W'(cur_debounce) + $urandom_range(0, 400);
				clock_ms += gap;
				send_event(btn, LEVEL_PRESSED, clock_ms);
				sent += 2;
				// contact bounce while still held
				if ($urandom_range(0, 3) == 0) begin
					clock_ms += $urandom_range(0, 20);
					send_event(btn, LEVEL_PRESSED, clock_ms);
					sent++;
				end
			end else begin
				send_event(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom());
				sent++;
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		sb = new();
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// reset colours and 100 ms debounce
		send_event(BTN_UP, LEVEL_PRESSED, 32'd0);          // too soon after reset
		send_event(BTN_UP, LEVEL_PRESSED, 32'd100);        // exactly the window
		send_event(BTN_UP, LEVEL_PRESSED, 32'd500);        // still held
		send_event(BTN_UP, LEVEL_RELEASED, 32'd510);
		send_event(BTN_UP, LEVEL_PRESSED, 32'd150);        // too soon
		send_event(BTN_UP, LEVEL_PRESSED, 32'd200);
		send_event(BTN_DOWN, LEVEL_PRESSED, 32'd50);       // too soon
		send_event(BTN_DOWN, LEVEL_PRESSED, 32'd120);
		send_event(BTN_DOWN, LEVEL_RELEASED, 32'd130);
		send_event(BTN_DOWN, LEVEL_PRESSED, 32'd300);      // down to 0
		send_event(BTN_DOWN, LEVEL_RELEASED, 32'd310);
		send_event(BTN_DOWN, LEVEL_PRESSED, 32'd500);      // 0 wraps to 9
		send_event(BTN_UP, LEVEL_RELEASED, 32'd600);
		send_event(BTN_UP, LEVEL_PRESSED, 32'd700);        // 9 wraps to 0
		send_event(BTN_DOWN, LEVEL_RELEASED, 32'hFFFF_FFF0);
		send_event(BTN_DOWN, LEVEL_PRESSED, 32'hFFFF_FFF0);
		send_event(BTN_DOWN, LEVEL_RELEASED, 32'h0000_0000);
		send_event(BTN_DOWN, LEVEL_PRESSED, 32'h0000_0060); // window across the wrap
		settle();

		// top extremes; upper data bits must be masked off the colour levels
		program_regs(16'hFFFF, 16'h00FF, 16'hFFFF, 16'hFFFF, REG_SPARE_HI);
		send_event(BTN_UP, LEVEL_RELEASED, 32'd800);
		send_event(BTN_UP, LEVEL_PRESSED, 32'd700 + 32'd65534); // one short
		send_event(BTN_UP, LEVEL_PRESSED, 32'd700 + 32'd65535);
		clock_ms = 32'd700 + 32'd65535;
		random_events(30);
		settle();

		// zero debounce: every press of a released button counts.
		// Receiver holds off while presses keep coming, so the block fills up.
		program_regs(CFG_DAT_W'($urandom()), CFG_DAT_W'($urandom()),
			CFG_DAT_W'($urandom()), 16'd0, REG_SPARE_LO);
		stall_req = 1'b1;
		for (int i = 0; i < 8; i++) begin
			send_event(BTN_UP, LEVEL_RELEASED, clock_ms);
			send_event(BTN_UP, LEVEL_PRESSED, clock_ms);
		end
		random_events(30);
		settle();

		// dark frames, cleared data bits, a stretch with no idling
		program_regs(16'h0000, 16'h0000, 16'h0000,
			CFG_DAT_W'($urandom_range(0, 500)), REG_SPARE_LO);
		steady = 1'b1;
		random_events(40);
		steady = 1'b0;
		settle();

		// random colours and debounce
		program_regs(CFG_DAT_W'($urandom()), CFG_DAT_W'($urandom()),
			CFG_DAT_W'($urandom()), CFG_DAT_W'($urandom_range(1, 300)), REG_SPARE_HI);
		random_events(35);

		// drain, then watch the output for any stray pixel
		push <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (sb.pending() != 0)
			$display("%0t: %0d expected pixels never arrived", $time, sb.pending());
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
